FILE: rtl/core/ajb_pkg.sv
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared sizes, register indexes and control types of the audio jitter buffer.
// ----------------------------------------------------------------------------
package ajb_pkg;

    // ring and block sizing
    localparam int RING_DEPTH   = 16384;
    localparam int MAX_FRAMES   = 64;
    localparam int MAX_CHANNELS = 8;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int FRAME_W = $clog2(MAX_FRAMES + 1);
    localparam int WANT_W  = $clog2(MAX_FRAMES * MAX_CHANNELS + 1);
    localparam int OFF_W   = WANT_W + 1;

    // fixed field widths
    localparam int SAMPLE_W   = 24;
    localparam int REQ_W      = 7;
    localparam int CH_W       = 4;
    localparam int THR_W      = 15;
    localparam int CNT_W      = 32;
    localparam int FILL_OUT_W = 15;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    // compare widths
    localparam int THR_CMP_W  = (FILL_W > THR_W) ? FILL_W : THR_W;
    localparam int WANT_CMP_W = (FILL_W > WANT_W) ? FILL_W : WANT_W;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PRIME_THRESHOLD = CFG_ADDR_W'(1);

    // configuration reset values
    localparam logic [CH_W-1:0]  CHANNEL_COUNT_RST   = CH_W'(1);
    localparam logic [THR_W-1:0] PRIME_THRESHOLD_RST = THR_W'(4800);

    // input action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic push;       // write one sample if room
        logic tick_load;  // latch request, channels and sample demand
        logic calc;       // settle priming, read length and counters
        logic rd_issue;   // launch ring read for current frame
        logic load;       // move one frame into the output register
    } ajb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_tick;     // offered item is a tick
        logic req_zero;    // offered tick asks for no frames
        logic last_frame;  // current frame closes the block
        logic out_free;    // output register can take a frame
    } ajb_stat_t;

    // ring pointer advance with wrap, n never exceeds the depth
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W:0]   n);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + n;
        if (sum >= (PTR_W + 1)'(RING_DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(RING_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/audio_jitter_buffer_priming_top.sv
// ----------------------------------------------------------------------------
// audio_jitter_buffer_priming_top
// FIFO jitter buffer for interleaved audio with priming, delivering channel 0
// of each requested frame with underrun and overrun accounting.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    action, sample_in, frame_request
//   out      source     out_valid / out_ready  sample_out, last_of_block,
//                                              was_priming, underrun_total,
//                                              overrun_total, fill_level
//   cfg      sink       cfg_wr_en              cfg_addr, cfg_wdata
//
// a push is taken while idle, so pushes stream one beat per cycle while no tick
// block is in progress; a tick runs a calculation step and then a ring read
// and an output load per frame, the registered ring read preceding each load
// a tick asking for zero frames is taken in idle and yields no beats
// the output register lets the next beat in while the last frame waits
// stalls on out_ready hold the frame sequencer; reset is asynchronous and
// leaves the ring contents untouched, no clearing pass is needed
// ----------------------------------------------------------------------------
module audio_jitter_buffer_priming_top import ajb_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic [REQ_W-1:0]            frame_request,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        last_of_block,
    output logic                        was_priming,
    output logic [CNT_W-1:0]            underrun_total,
    output logic [CNT_W-1:0]            overrun_total,
    output logic [FILL_OUT_W-1:0]       fill_level
);

    ajb_cmd_t  cmd;
    ajb_stat_t stat;

    // sequencer
    ajb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring, counters and output register
    ajb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .action         (action),
        .sample_in      (sample_in),
        .frame_request  (frame_request),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .last_of_block  (last_of_block),
        .was_priming    (was_priming),
        .underrun_total (underrun_total),
        .overrun_total  (overrun_total),
        .fill_level     (fill_level)
    );

endmodule

FILE: rtl/core/ajb_ram.sv
// ----------------------------------------------------------------------------
// ajb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ajb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/ajb_datapath.sv
// ----------------------------------------------------------------------------
// ajb_datapath
// Ring storage, pointers, fill and error counters, block bookkeeping and the
// output register of the audio jitter buffer.
// ----------------------------------------------------------------------------
module ajb_datapath import ajb_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    // input payload
    input  logic                         action,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    input  logic [REQ_W-1:0]             frame_request,
    // control
    input  ajb_cmd_t                     cmd,
    output ajb_stat_t                    stat,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]   sample_out,
    output logic                         last_of_block,
    output logic                         was_priming,
    output logic [CNT_W-1:0]             underrun_total,
    output logic [CNT_W-1:0]             overrun_total,
    output logic [FILL_OUT_W-1:0]        fill_level
);

    // configuration registers
    logic [CH_W-1:0]  channel_count_reg;
    logic [THR_W-1:0] prime_threshold_reg;

    // ring state
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  rd_base_reg, rd_base_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              running_reg, running_next;
    logic [CNT_W-1:0]  underrun_reg, underrun_next;
    logic [CNT_W-1:0]  overrun_reg, overrun_next;

    // block bookkeeping
    logic [FRAME_W-1:0] frames_reg, frames_next;
    logic [FRAME_W-1:0] frame_idx_reg, frame_idx_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic [WANT_W-1:0]  to_read_reg, to_read_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic               priming_blk_reg, priming_blk_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       last_out_reg;
    logic                       priming_out_reg;
    logic [CNT_W-1:0]           underrun_out_reg;
    logic [CNT_W-1:0]           overrun_out_reg;
    logic [FILL_OUT_W-1:0]      fill_out_reg;

    // helpers
    logic                 push_ok;
    logic [FRAME_W-1:0]   req_sat;
    logic [CH_W-1:0]      ch_sat;
    logic                 thr_met;
    logic                 calc_priming;
    logic [WANT_W-1:0]    calc_read;
    logic [WANT_W-1:0]    shortfall;
    logic [CNT_W:0]       under_sum;
    logic [CNT_W:0]       over_sum;
    logic                 frame_complete;
    logic [PTR_W-1:0]     rd_addr;
    logic [SAMPLE_W-1:0]  ram_rd_data;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg   <= CHANNEL_COUNT_RST;
            prime_threshold_reg <= PRIME_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == REG_CHANNEL_COUNT)
            begin
                channel_count_reg <= cfg_wdata[CH_W-1:0];
            end
            else if (cfg_addr == REG_PRIME_THRESHOLD)
            begin
                prime_threshold_reg <= cfg_wdata[THR_W-1:0];
            end
        end
    end

    // request and channel saturation
    always_comb
    begin
        if (frame_request > REQ_W'(MAX_FRAMES))
        begin
            req_sat = FRAME_W'(MAX_FRAMES);
        end
        else
        begin
            req_sat = FRAME_W'(frame_request);
        end

        if (channel_count_reg == '0)
        begin
            ch_sat = CH_W'(1);
        end
        else if (channel_count_reg > CH_W'(MAX_CHANNELS))
        begin
            ch_sat = CH_W'(MAX_CHANNELS);
        end
        else
        begin
            ch_sat = channel_count_reg;
        end
    end

    // priming decision and read length for the block
    always_comb
    begin
        thr_met = THR_CMP_W'(fill_reg) >= THR_CMP_W'(prime_threshold_reg);
        calc_priming = !running_reg && !thr_met;
        if (calc_priming)
        begin
            calc_read = '0;
        end
        else if (WANT_CMP_W'(want_reg) < WANT_CMP_W'(fill_reg))
        begin
            calc_read = want_reg;
        end
        else
        begin
            calc_read = WANT_W'(fill_reg);
        end
        shortfall = calc_priming ? '0 : (want_reg - calc_read);
        under_sum = {1'b0, underrun_reg} + (CNT_W + 1)'(shortfall);
        over_sum  = {1'b0, overrun_reg} + (CNT_W + 1)'(1);
    end

    // push path
    assign push_ok = cmd.push && (fill_reg < FILL_W'(RING_DEPTH));

    // a frame carries its sample only if all its channels were read, else silence
    assign frame_complete = (offset_reg + OFF_W'(ch_reg)) <= OFF_W'(to_read_reg);
    assign rd_addr = ring_add(rd_base_reg, (PTR_W + 1)'(offset_reg));

    // next state of ring and block registers
    always_comb
    begin
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_base_next     = rd_base_reg;
        fill_next        = fill_reg;
        running_next     = running_reg;
        underrun_next    = underrun_reg;
        overrun_next     = overrun_reg;
        frames_next      = frames_reg;
        frame_idx_next   = frame_idx_reg;
        ch_next          = ch_reg;
        want_next        = want_reg;
        to_read_next     = to_read_reg;
        offset_next      = offset_reg;
        priming_blk_next = priming_blk_reg;

        if (push_ok)
        begin
            wr_ptr_next = ring_add(wr_ptr_reg, (PTR_W + 1)'(1));
            fill_next   = fill_reg + FILL_W'(1);
        end
        else if (cmd.push)
        begin
            overrun_next = over_sum[CNT_W] ? '1 : over_sum[CNT_W-1:0];
        end

        if (cmd.tick_load)
        begin
            frames_next    = req_sat;
            ch_next        = ch_sat;
            want_next      = WANT_W'(req_sat) * WANT_W'(ch_sat);
            frame_idx_next = '0;
            offset_next    = '0;
        end

        if (cmd.calc)
        begin
            priming_blk_next = calc_priming;
            to_read_next     = calc_read;
            rd_base_next     = rd_ptr_reg;
            rd_ptr_next      = ring_add(rd_ptr_reg, (PTR_W + 1)'(calc_read));
            fill_next        = fill_reg - FILL_W'(calc_read);
            if (!calc_priming)
            begin
                running_next = (calc_read == want_reg);
                underrun_next = under_sum[CNT_W] ? '1 : under_sum[CNT_W-1:0];
            end
        end

        if (cmd.load)
        begin
            frame_idx_next = frame_idx_reg + FRAME_W'(1);
            offset_next    = offset_reg + OFF_W'(ch_reg);
        end
    end

    // control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            running_reg   <= 1'b0;
            underrun_reg  <= '0;
            overrun_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            running_reg   <= running_next;
            underrun_reg  <= underrun_next;
            overrun_reg   <= overrun_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // block payload registers
    always_ff @(posedge clk)
    begin
        rd_base_reg     <= rd_base_next;
        frames_reg      <= frames_next;
        frame_idx_reg   <= frame_idx_next;
        ch_reg          <= ch_next;
        want_reg        <= want_next;
        to_read_reg     <= to_read_next;
        offset_reg      <= offset_next;
        priming_blk_reg <= priming_blk_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_out_reg   <= frame_complete ? $signed(ram_rd_data) : '0;
            last_out_reg     <= stat.last_frame;
            priming_out_reg  <= priming_blk_reg;
            underrun_out_reg <= underrun_reg;
            overrun_out_reg  <= overrun_reg;
            fill_out_reg     <= FILL_OUT_W'(fill_reg);
        end
    end

    // ring storage
    ajb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (wr_ptr_reg),
        .wr_data (sample_in),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // status to controller
    assign stat.in_tick    = (action == ACT_TICK);
    assign stat.req_zero   = (frame_request == '0);
    assign stat.last_frame = (frame_idx_reg + FRAME_W'(1)) == frames_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // output ports
    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_out_reg;
    assign last_of_block  = last_out_reg;
    assign was_priming    = priming_out_reg;
    assign underrun_total = underrun_out_reg;
    assign overrun_total  = overrun_out_reg;
    assign fill_level     = fill_out_reg;

    // fill never passes the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill above ring depth");

    // empty or full ring has pointers together
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0 || fill_reg == FILL_W'(RING_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers disagree with fill");

    // a frame is never loaded over one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");

    // priming blocks carry silence
    a_prime_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && priming_out_reg) |-> (sample_out_reg == '0))
        else $error("priming block not silent");

endmodule

FILE: rtl/core/ajb_ctrl.sv
// ----------------------------------------------------------------------------
// ajb_ctrl
// Sequencer of the audio jitter buffer: takes beats, runs the per-block
// calculation and steps through the frames of a tick.
// ----------------------------------------------------------------------------
module ajb_ctrl import ajb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ajb_stat_t stat,
    output ajb_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!stat.in_tick)
                    begin
                        cmd.push = 1'b1;
                    end
                    else if (!stat.req_zero)
                    begin
                        cmd.tick_load = 1'b1;
                        state_next    = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.last_frame ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input taken only while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_ready)
        else $error("beat taken during block");

    // calculation always follows a tick load
    a_calc_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_load |=> cmd.calc)
        else $error("calc did not follow tick load");

endmodule
